[rtl/pjs_pkg.sv]
// Shared types, constants and helper functions of the heap scheduler.
`default_nettype none
package pjs_pkg;

    localparam int CAPACITY  = 63;
    localparam int LEVELS    = $clog2(CAPACITY + 1);
    localparam int CNT_W     = LEVELS;
    localparam int LVL_W     = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int PW        = (LEVELS > 2) ? LEVELS - 1 : 2;
    localparam int PAIR_AW   = PW - 1;
    localparam int IDX_W     = LEVELS + 1;

    localparam int ID_W      = 16;
    localparam int PRIO_W    = 8;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int OP_W      = 2;
    localparam int ENTRY_W   = ID_W + PRIO_W + LEN_W;
    localparam int S_DATA_W  = ENTRY_W;
    localparam int M_DATA_W  = ID_W + TIME_W;

    typedef enum logic [OP_W-1:0] {
        OP_EXEC   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DRAIN  = 2'd2
    } t_op;

    typedef struct packed {
        logic        [LEN_W-1:0]  len;
        logic signed [PRIO_W-1:0] prio;
        logic        [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        t_entry odd;
        t_entry even;
    } t_pair;

    typedef enum logic {
        TK_INS,
        TK_DOWN
    } t_tkind;

    typedef struct packed {
        logic             valid;
        t_tkind           kind;
        logic [PW-1:0]    pos;
        logic [LVL_W-1:0] ins_lvl;
        logic [PW-1:0]    ins_pos;
        t_entry           carry;
    } t_tok;

    typedef struct packed {
        logic             valid;
        logic [LVL_W-1:0] lvl;
        logic [PW-1:0]    pos;
    } t_fetch;

    typedef struct packed {
        logic               valid;
        logic [PAIR_AW-1:0] addr;
    } t_rdreq;

    typedef struct packed {
        logic [PAIR_AW-1:0] raddr;
        logic [PAIR_AW-1:0] waddr;
        logic               we_even;
        logic               we_odd;
        t_entry             wdata;
    } t_ramctl;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [PW-1:0]    pos;
    } t_slot;

    typedef struct packed {
        logic              last;
        logic              status;
        logic [TIME_W-1:0] ftime;
        logic [ID_W-1:0]   id;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_FETCH,
        ST_POP,
        ST_SIFT,
        ST_EMIT
    } t_state;

    // level and in-level position of heap slot m-1 (m >= 1)
    function automatic t_slot f_slot(input logic [CNT_W-1:0] m);
        t_slot            s;
        logic [CNT_W-1:0] msb;
        s.lvl = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (m[b]) begin
                s.lvl = LVL_W'(b);
            end
        end
        msb   = CNT_W'(1) << s.lvl;
        s.pos = PW'(m ^ msb);
        return s;
    endfunction

    // global index of the left child of a node
    function automatic logic [IDX_W-1:0] f_left(input logic [LVL_W-1:0] lvl,
                                               input logic [PW-1:0]    pos);
        return (IDX_W'(2) << lvl) - IDX_W'(1) + (IDX_W'(pos) << 1);
    endfunction

    function automatic logic [TIME_W-1:0] f_sat_add(input logic [TIME_W-1:0] t,
                                                   input logic [LEN_W-1:0]  len);
        logic [TIME_W:0] s;
        s = {1'b0, t} + (TIME_W+1)'(len);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/pjs_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pjs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/pjs_cell.sv]
// One heap level: insert and sift-down step, handing the carried entry down.
`default_nettype none
module pjs_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [pjs_pkg::LVL_W-1:0]    i_level,
    input  wire logic [pjs_pkg::CNT_W-1:0]    i_count,
    input  wire pjs_pkg::t_tok                i_tok,
    output pjs_pkg::t_tok                     o_tok,
    output logic                              o_done,
    input  wire pjs_pkg::t_fetch              i_fetch,
    input  wire pjs_pkg::t_rdreq              i_parent_rd,
    output pjs_pkg::t_rdreq                   o_child_rd,
    input  wire pjs_pkg::t_pair               i_child_data,
    input  wire pjs_pkg::t_pair               i_ram_rd,
    output pjs_pkg::t_ramctl                  o_ram
);

    logic                             r_hold;
    logic                             n_hold;
    pjs_pkg::t_tok                    r_tok;
    pjs_pkg::t_tok                    n_tok;
    pjs_pkg::t_tok                    r_out;
    pjs_pkg::t_tok                    n_out;
    logic [pjs_pkg::PW-1:0]           p1_pos;
    logic [pjs_pkg::IDX_W-1:0]        left1;
    logic [pjs_pkg::IDX_W-1:0]        left2;
    logic [pjs_pkg::IDX_W-1:0]        cnt_x;
    pjs_pkg::t_entry                  own_n;
    pjs_pkg::t_entry                  child_c;
    logic                             pick_r;
    logic                             wr;
    logic [pjs_pkg::PW-1:0]           wr_pos;
    pjs_pkg::t_entry                  wr_data;
    logic                             rd_own;

    assign p1_pos  = (i_tok.kind == pjs_pkg::TK_INS)
                   ? pjs_pkg::PW'(i_tok.ins_pos >> (i_tok.ins_lvl - i_level))
                   : i_tok.pos;
    assign left1   = pjs_pkg::f_left(i_level, p1_pos);
    assign left2   = pjs_pkg::f_left(i_level, r_tok.pos);
    assign cnt_x   = pjs_pkg::IDX_W'(i_count);
    assign own_n   = r_tok.pos[0] ? i_ram_rd.odd : i_ram_rd.even;
    assign pick_r  = ((left2 + pjs_pkg::IDX_W'(1)) < cnt_x)
                   && !($signed(i_child_data.even.prio) < $signed(i_child_data.odd.prio));
    assign child_c = pick_r ? i_child_data.odd : i_child_data.even;

    always_comb begin
        n_hold     = 1'b0;
        n_tok      = r_tok;
        n_out      = '0;
        o_done     = 1'b0;
        o_child_rd = '0;
        wr         = 1'b0;
        wr_pos     = r_tok.pos;
        wr_data    = r_tok.carry;
        rd_own     = 1'b0;
        if (i_tok.valid) begin
            n_tok     = i_tok;
            n_tok.pos = p1_pos;
            if (i_tok.kind == pjs_pkg::TK_INS) begin
                if (i_level == i_tok.ins_lvl) begin
                    wr      = 1'b1;
                    wr_pos  = p1_pos;
                    wr_data = i_tok.carry;
                    o_done  = 1'b1;
                end else begin
                    rd_own = 1'b1;
                    n_hold = 1'b1;
                end
            end else begin
                if (left1 >= cnt_x) begin
                    wr      = 1'b1;
                    wr_pos  = p1_pos;
                    wr_data = i_tok.carry;
                    o_done  = 1'b1;
                end else begin
                    o_child_rd.valid = 1'b1;
                    o_child_rd.addr  = pjs_pkg::PAIR_AW'(p1_pos);
                    n_hold           = 1'b1;
                end
            end
        end else if (r_hold) begin
            n_out       = r_tok;
            n_out.valid = 1'b1;
            wr          = 1'b1;
            if (r_tok.kind == pjs_pkg::TK_INS) begin
                if ($signed(r_tok.carry.prio) <= $signed(own_n.prio)) begin
                    n_out.carry = own_n;
                end else begin
                    wr_data = own_n;
                end
            end else begin
                if ($signed(r_tok.carry.prio) >= $signed(child_c.prio)) begin
                    wr_data   = child_c;
                    n_out.pos = {r_tok.pos[pjs_pkg::PW-2:0], pick_r};
                end else begin
                    n_out  = '0;
                    o_done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_ram.wdata   = wr_data;
        o_ram.waddr   = wr_pos[pjs_pkg::PW-1:1];
        o_ram.we_even = wr && !wr_pos[0];
        o_ram.we_odd  = wr && wr_pos[0];
        if (i_parent_rd.valid) begin
            o_ram.raddr = i_parent_rd.addr;
        end else if (rd_own) begin
            o_ram.raddr = p1_pos[pjs_pkg::PW-1:1];
        end else if (i_fetch.valid && (i_fetch.lvl == i_level)) begin
            o_ram.raddr = i_fetch.pos[pjs_pkg::PW-1:1];
        end else begin
            o_ram.raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_out  <= '0;
        end else begin
            r_hold <= n_hold;
            r_out  <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_out;

endmodule
`default_nettype wire

[rtl/pjs_ctrl.sv]
// Command sequencer: stream handshakes, job count, elapsed time, result register.
`default_nettype none
module pjs_ctrl (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic [pjs_pkg::S_DATA_W-1:0]          i_s_tdata,
    input  wire logic [pjs_pkg::OP_W-1:0]              i_s_tuser,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    output logic [pjs_pkg::M_DATA_W-1:0]               o_m_tdata,
    output logic                                       o_m_tuser,
    output logic                                       o_m_tlast,
    input  wire logic                                  i_done,
    input  wire pjs_pkg::t_pair [pjs_pkg::LEVELS-1:0]  i_rd_all,
    output pjs_pkg::t_tok                              o_tok,
    output pjs_pkg::t_fetch                            o_fetch,
    output logic [pjs_pkg::CNT_W-1:0]                  o_count
);

    pjs_pkg::t_state                   r_state;
    pjs_pkg::t_state                   n_state;
    logic [pjs_pkg::CNT_W-1:0]         r_count;
    logic [pjs_pkg::TIME_W-1:0]        r_time;
    logic                              r_drain;
    pjs_pkg::t_tok                     r_tok;
    pjs_pkg::t_tok                     n_tok;
    pjs_pkg::t_res                     r_res;
    pjs_pkg::t_res                     r_m;
    logic                              r_m_valid;
    logic                              accept;
    logic                              load_out;
    logic                              full;
    logic                              empty;
    pjs_pkg::t_op                      op;
    pjs_pkg::t_slot                    ins_slot;
    pjs_pkg::t_slot                    last_slot;
    pjs_pkg::t_entry                   root;
    pjs_pkg::t_entry                   last_e;
    pjs_pkg::t_pair                    last_pair;
    logic [pjs_pkg::TIME_W-1:0]        new_time;

    assign op        = pjs_pkg::t_op'(i_s_tuser);
    assign full      = (r_count == pjs_pkg::CNT_W'(pjs_pkg::CAPACITY));
    assign empty     = (r_count == '0);
    assign ins_slot  = pjs_pkg::f_slot(r_count + pjs_pkg::CNT_W'(1));
    assign last_slot = pjs_pkg::f_slot(r_count);
    assign root      = i_rd_all[0].even;
    assign last_pair = i_rd_all[last_slot.lvl];
    assign last_e    = last_slot.pos[0] ? last_pair.odd : last_pair.even;
    assign new_time  = pjs_pkg::f_sat_add(r_time, root.len);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pjs_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (op)
                        pjs_pkg::OP_EXEC:   n_state = empty ? pjs_pkg::ST_EMIT : pjs_pkg::ST_FETCH;
                        pjs_pkg::OP_INSERT: n_state = full ? pjs_pkg::ST_IDLE : pjs_pkg::ST_INS;
                        pjs_pkg::OP_DRAIN:  n_state = empty ? pjs_pkg::ST_IDLE : pjs_pkg::ST_FETCH;
                        default:            n_state = pjs_pkg::ST_IDLE;
                    endcase
                end
            end
            pjs_pkg::ST_INS:   n_state = i_done ? pjs_pkg::ST_IDLE : pjs_pkg::ST_INS;
            pjs_pkg::ST_FETCH: n_state = pjs_pkg::ST_POP;
            pjs_pkg::ST_POP: begin
                n_state = (r_count == pjs_pkg::CNT_W'(1)) ? pjs_pkg::ST_EMIT : pjs_pkg::ST_SIFT;
            end
            pjs_pkg::ST_SIFT:  n_state = i_done ? pjs_pkg::ST_EMIT : pjs_pkg::ST_SIFT;
            pjs_pkg::ST_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = (r_drain && !empty) ? pjs_pkg::ST_FETCH : pjs_pkg::ST_IDLE;
                end
            end
            default:           n_state = pjs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == pjs_pkg::ST_IDLE) && i_rst_n;
        accept     = o_s_tready && i_s_tvalid;
        load_out   = (r_state == pjs_pkg::ST_EMIT) && (!r_m_valid || i_m_tready);
        o_fetch    = '0;
        n_tok      = '0;
        if (r_state == pjs_pkg::ST_FETCH) begin
            o_fetch.valid = 1'b1;
            o_fetch.lvl   = last_slot.lvl;
            o_fetch.pos   = last_slot.pos;
        end
        if (accept && (op == pjs_pkg::OP_INSERT) && !full) begin
            n_tok.valid   = 1'b1;
            n_tok.kind    = pjs_pkg::TK_INS;
            n_tok.ins_lvl = ins_slot.lvl;
            n_tok.ins_pos = ins_slot.pos;
            n_tok.carry   = pjs_pkg::t_entry'(i_s_tdata);
        end else if ((r_state == pjs_pkg::ST_POP) && (r_count != pjs_pkg::CNT_W'(1))) begin
            n_tok.valid   = 1'b1;
            n_tok.kind    = pjs_pkg::TK_DOWN;
            n_tok.carry   = last_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pjs_pkg::ST_IDLE;
            r_count   <= '0;
            r_time    <= '0;
            r_drain   <= 1'b0;
            r_tok     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            if (accept) begin
                case (op)
                    pjs_pkg::OP_EXEC:   r_drain <= 1'b0;
                    pjs_pkg::OP_INSERT: begin
                        if (!full) begin
                            r_count <= r_count + pjs_pkg::CNT_W'(1);
                        end
                    end
                    pjs_pkg::OP_DRAIN: begin
                        r_drain <= 1'b1;
                        if (empty) begin
                            r_time <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == pjs_pkg::ST_POP) begin
                r_count <= r_count - pjs_pkg::CNT_W'(1);
                r_time  <= new_time;
            end
            if (load_out && r_drain && empty) begin
                r_time <= '0;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (op == pjs_pkg::OP_EXEC) && empty) begin
            r_res.id     <= '0;
            r_res.ftime  <= r_time;
            r_res.status <= 1'b1;
            r_res.last   <= 1'b1;
        end else if (r_state == pjs_pkg::ST_POP) begin
            r_res.id     <= root.id;
            r_res.ftime  <= new_time;
            r_res.status <= 1'b0;
            r_res.last   <= r_drain ? (r_count == pjs_pkg::CNT_W'(1)) : 1'b1;
        end
        if (load_out) begin
            r_m <= r_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m.ftime, r_m.id};
    assign o_m_tuser  = r_m.status;
    assign o_m_tlast  = r_m.last;
    assign o_tok      = r_tok;
    assign o_count    = r_count;

endmodule
`default_nettype wire

[rtl/priority_job_scheduler_heap_core.sv]
// Top level of the job scheduler: sequencer plus one heap-level cell per tree level.
//
// Jobs live in a binary min-heap on signed priority, one cell per tree level and one
// pair of small RAMs per level below the root, which has a single RAM (6 levels for
// 63 jobs). The carried entry walks from the root cell toward the leaves, each level
// doing a registered RAM read, then a compare and a write. An insert carries the new
// entry down to its new slot, at a depth of 0 to 5. An execute pops the root and sinks
// the last entry down from the root in its place. A drain pops every job in turn as
// an execute does. One item is worked on at a time; a finished result waits in an
// output register and the next item is taken while it waits, and a second result
// holds the sequencer until that register frees. Reset leaves the heap empty with no
// clearing pass.
`default_nettype none
module priority_job_scheduler_heap_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // job_id[15:0], priority_req[23:16], work_length[39:24]
    input  wire logic [pjs_pkg::S_DATA_W-1:0]      i_s_tdata,
    // op[1:0]
    input  wire logic [pjs_pkg::OP_W-1:0]          i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // done_job_id[15:0], finish_time[47:16]
    output logic [pjs_pkg::M_DATA_W-1:0]           o_m_tdata,
    // status[0]
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast
);

    pjs_pkg::t_tok                      tok      [pjs_pkg::LEVELS+1];
    pjs_pkg::t_rdreq                    crd      [pjs_pkg::LEVELS+1];
    pjs_pkg::t_pair [pjs_pkg::LEVELS-1:0] rd_all;
    pjs_pkg::t_ramctl                   ramc     [pjs_pkg::LEVELS];
    logic [pjs_pkg::LEVELS-1:0]         cell_done;
    pjs_pkg::t_fetch                    fetch;
    logic [pjs_pkg::CNT_W-1:0]          count;

    assign crd[0] = '0;

    pjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_done     (|cell_done),
        .i_rd_all   (rd_all),
        .o_tok      (tok[0]),
        .o_fetch    (fetch),
        .o_count    (count)
    );

    for (genvar k = 0; k < pjs_pkg::LEVELS; k++) begin : g_lvl
        localparam int DEPTH_K = (k == 0) ? 1 : (1 << (k - 1));
        localparam int AW_K    = (DEPTH_K > 1) ? $clog2(DEPTH_K) : 1;
        pjs_pkg::t_pair child_data;

        if (k == pjs_pkg::LEVELS - 1) begin : g_leaf
            assign child_data = '0;
        end else begin : g_inner
            assign child_data = rd_all[k+1];
        end

        pjs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_level      (pjs_pkg::LVL_W'(k)),
            .i_count      (count),
            .i_tok        (tok[k]),
            .o_tok        (tok[k+1]),
            .o_done       (cell_done[k]),
            .i_fetch      (fetch),
            .i_parent_rd  (crd[k]),
            .o_child_rd   (crd[k+1]),
            .i_child_data (child_data),
            .i_ram_rd     (rd_all[k]),
            .o_ram        (ramc[k])
        );

        pjs_ram #(
            .WIDTH (pjs_pkg::ENTRY_W),
            .DEPTH (DEPTH_K)
        ) u_ram_even (
            .i_clk   (i_clk),
            .i_we    (ramc[k].we_even),
            .i_waddr (ramc[k].waddr[AW_K-1:0]),
            .i_wdata (ramc[k].wdata),
            .i_raddr (ramc[k].raddr[AW_K-1:0]),
            .o_rdata (rd_all[k].even)
        );

        if (k == 0) begin : g_root
            assign rd_all[k].odd = '0;
        end else begin : g_odd
            pjs_ram #(
                .WIDTH (pjs_pkg::ENTRY_W),
                .DEPTH (DEPTH_K)
            ) u_ram_odd (
                .i_clk   (i_clk),
                .i_we    (ramc[k].we_odd),
                .i_waddr (ramc[k].waddr[AW_K-1:0]),
                .i_wdata (ramc[k].wdata),
                .i_raddr (ramc[k].raddr[AW_K-1:0]),
                .o_rdata (rd_all[k].odd)
            );
        end
    end

endmodule
`default_nettype wire

[rtl/pjs_chk.sv]
// Port-level checker for the heap scheduler, bound to the top level.
`default_nettype none
module pjs_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic [pjs_pkg::S_DATA_W-1:0]  i_s_tdata,
    input wire logic [pjs_pkg::OP_W-1:0]      i_s_tuser,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [pjs_pkg::M_DATA_W-1:0]  o_m_tdata,
    input wire logic                          o_m_tuser,
    input wire logic                          o_m_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser)
                                      && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata[15:0] == 16'd0))
        else $error("empty-queue beat without last or with a job id");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result beat appeared one cycle after an input beat");

endmodule

bind priority_job_scheduler_heap_core pjs_chk u_pjs_chk (.*);
`default_nettype wire
